// ===== src/io_sample_frame_window_parser_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef IO_SAMPLE_FRAME_WINDOW_PARSER_MACROS_SVH
`define IO_SAMPLE_FRAME_WINDOW_PARSER_MACROS_SVH

// Same-cycle implication, checked on clk and ignored while arst_n is low.
`define ISP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// Next-cycle implication, checked on clk and ignored while arst_n is low.
`define ISP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

// ===== src/isp_pkg.sv =====
// Types and constants of the IO-sample frame window parser.
package isp_pkg;

	localparam int CFG_IDX_W     = 3;
	localparam int FRAME_OFFSETS = 28;

	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WANTED_TYPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ONE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_TWO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_THREE   = 3'd4;

	localparam logic [7:0]  RST_START_MARKER = 8'h7E;
	localparam logic [7:0]  RST_WANTED_TYPE  = 8'h92;
	localparam logic [31:0] RST_NODE_ONE     = 32'h4089CB96;
	localparam logic [31:0] RST_NODE_TWO     = 32'h40683F8D;
	localparam logic [31:0] RST_NODE_THREE   = 32'h4089CB93;

	localparam logic [7:0] CHECKSUM_BASE = 8'hFF;

	localparam logic [1:0] NODE_UNKNOWN = 2'd0;
	localparam logic [1:0] NODE_ONE     = 2'd1;
	localparam logic [1:0] NODE_TWO     = 2'd2;
	localparam logic [1:0] NODE_THREE   = 2'd3;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  wanted_frame_type;
		logic [31:0] node_one_low_address;
		logic [31:0] node_two_low_address;
		logic [31:0] node_three_low_address;
	} isp_cfg_t;

	typedef struct packed {
		logic        frame_accepted;
		logic        type_match;
		logic [63:0] source_address;
		logic [15:0] network_address;
		logic [1:0]  node_class;
		logic [2:0]  analog_count;
		logic [15:0] sample_zero;
		logic [15:0] sample_one;
		logic [15:0] sample_two;
		logic [15:0] sample_three;
		logic [31:0] starts_seen;
		logic [31:0] type_matches_seen;
	} isp_result_t;

endpackage

// ===== src/isp_if.sv =====
// Channel interfaces of the parser: received bytes, results and register writes.
interface isp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface isp_result_if;
	logic                valid;
	logic                ready;
	isp_pkg::isp_result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface isp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [isp_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/isp_cell.sv =====
// One byte cell of the receive window; it passes its byte on at every shift.
module isp_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] d,
	output logic [7:0] q
);
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;
endmodule

// ===== src/isp_decode.sv =====
// Frame decoder: reads the window at fixed offsets and checks the checksum.
module isp_decode #(
	parameter int WINDOW_BYTES = 29,
	parameter int MAX_CHANNELS = 4
) (
	input  logic [WINDOW_BYTES-1:0][7:0] win,
	input  isp_pkg::isp_cfg_t             cfg,
	output logic                          start_hit,
	output isp_pkg::isp_result_t          dec
);
	import isp_pkg::*;

	localparam logic [2:0] MAX_CH = 3'(MAX_CHANNELS);

	logic [7:0]  fb [FRAME_OFFSETS];
	logic [2:0]  raw_cnt;
	logic [2:0]  cnt;
	logic [7:0]  amask;
	logic [3:0]  present;
	logic [15:0] smp [4];
	logic [7:0]  terms [24];
	logic [7:0]  lvl1 [12];
	logic [7:0]  lvl2 [6];
	logic [7:0]  sum;
	logic [7:0]  chk;
	logic [7:0]  calc;
	logic [31:0] low;
	logic        tmatch;

	// Offsets that fall below the newest position read as zero.
	for (genvar o = 0; o < FRAME_OFFSETS; o++) begin : g_fb
		if (o <= WINDOW_BYTES - 1) begin : g_in
			assign fb[o] = win[WINDOW_BYTES-1-o];
		end else begin : g_out
			assign fb[o] = '0;
		end
	end

	assign start_hit = (fb[0] == cfg.start_marker);
	assign amask     = fb[18];
	assign raw_cnt   = 3'(amask[0]) + 3'(amask[1]) + 3'(amask[2]) + 3'(amask[3]);
	assign cnt       = (raw_cnt > MAX_CH) ? MAX_CH : raw_cnt;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			present[k] = (k < MAX_CHANNELS) && (3'(k) < cnt);
			smp[k]     = present[k] ? {fb[19+2*k], fb[20+2*k]} : 16'd0;
		end
	end

	// Checksum terms: frame type through analog mask, then the active samples.
	always_comb begin
		for (int t = 0; t < 16; t++) begin
			terms[t] = fb[3+t];
		end
		for (int k = 0; k < 4; k++) begin
			terms[16+2*k] = smp[k][15:8];
			terms[17+2*k] = smp[k][7:0];
		end
		for (int i = 0; i < 12; i++) begin
			lvl1[i] = terms[2*i] + terms[2*i+1];
		end
		for (int i = 0; i < 6; i++) begin
			lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
		end
		sum = (lvl2[0] + lvl2[1]) + (lvl2[2] + lvl2[3]) + (lvl2[4] + lvl2[5]);
	end

	always_comb begin
		case (cnt)
			3'd0:    chk = fb[19];
			3'd1:    chk = fb[21];
			3'd2:    chk = fb[23];
			3'd3:    chk = fb[25];
			default: chk = fb[27];
		endcase
	end

	assign calc   = CHECKSUM_BASE - sum;
	assign tmatch = (fb[3] == cfg.wanted_frame_type);
	assign low    = {fb[8], fb[9], fb[10], fb[11]};

	always_comb begin
		dec                   = '0;
		dec.type_match        = tmatch;
		dec.frame_accepted    = tmatch && (calc == chk);
		dec.source_address    = {fb[4], fb[5], fb[6], fb[7], fb[8], fb[9], fb[10], fb[11]};
		dec.network_address   = {fb[12], fb[13]};
		dec.analog_count      = cnt;
		dec.sample_zero       = smp[0];
		dec.sample_one        = smp[1];
		dec.sample_two        = smp[2];
		dec.sample_three      = smp[3];
		// The lowest matching node number wins when registers hold equal values.
		if (low == cfg.node_one_low_address) begin
			dec.node_class = NODE_ONE;
		end else if (low == cfg.node_two_low_address) begin
			dec.node_class = NODE_TWO;
		end else if (low == cfg.node_three_low_address) begin
			dec.node_class = NODE_THREE;
		end else begin
			dec.node_class = NODE_UNKNOWN;
		end
	end
endmodule

// ===== src/io_sample_frame_window_parser.sv =====
// Top level of the IO-sample frame window parser.
// Received bytes shift through a row of WINDOW_BYTES byte cells, one byte per cycle. The
// cycle after a byte is taken, the decoder looks at the window; when the oldest byte is the
// start marker, one result with addresses, node class, samples and running counters is
// registered and offered on the result channel once output is free. A new byte is taken in
// every cycle; the rate drops only while a result waits in the output register and the next
// window also holds a start marker. Other bytes give no result. Registers are written through
// the configuration channel, which is always ready; indexes beyond the list are ignored.
module io_sample_frame_window_parser #(
	parameter int WINDOW_BYTES = 29,
	parameter int MAX_CHANNELS = 4
) (
	input logic         clk,
	input logic         arst_n,
	isp_byte_if.sink    rx,
	isp_result_if.source res,
	isp_cfg_if.sink     cfg
);
	import isp_pkg::*;

	`include "io_sample_frame_window_parser_macros.svh"

	isp_cfg_t                      cfg_q;
	logic [WINDOW_BYTES-1:0][7:0] win;
	logic                          rx_acc;
	logic                          fresh_q;
	logic                          start_hit;
	logic                          advance;
	logic                          load;
	logic                          out_valid_q;
	isp_result_t                   dec;
	isp_result_t                   load_res;
	isp_result_t                   res_q;
	logic [31:0]                   start_cnt_q;
	logic [31:0]                   type_cnt_q;
	logic [31:0]                   start_cnt_next;
	logic [31:0]                   type_cnt_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker           <= RST_START_MARKER;
			cfg_q.wanted_frame_type      <= RST_WANTED_TYPE;
			cfg_q.node_one_low_address   <= RST_NODE_ONE;
			cfg_q.node_two_low_address   <= RST_NODE_TWO;
			cfg_q.node_three_low_address <= RST_NODE_THREE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_MARKER: cfg_q.start_marker           <= cfg.data[7:0];
				REG_WANTED_TYPE:  cfg_q.wanted_frame_type      <= cfg.data[7:0];
				REG_NODE_ONE:     cfg_q.node_one_low_address   <= cfg.data;
				REG_NODE_TWO:     cfg_q.node_two_low_address   <= cfg.data;
				REG_NODE_THREE:   cfg_q.node_three_low_address <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign rx_acc = rx.valid && rx.ready;

	for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
		if (i == 0) begin : g_head
			isp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (rx_acc),
				.d      (rx.rx_byte),
				.q      (win[i])
			);
		end else begin : g_body
			isp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (rx_acc),
				.d      (win[i-1]),
				.q      (win[i])
			);
		end
	end

	isp_decode #(
		.WINDOW_BYTES (WINDOW_BYTES),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_decode (
		.win       (win),
		.cfg       (cfg_q),
		.start_hit (start_hit),
		.dec       (dec)
	);

	// The window may only shift once its current contents have been decoded.
	assign advance  = fresh_q && (!start_hit || !out_valid_q || res.ready);
	assign load     = fresh_q && start_hit && (!out_valid_q || res.ready);
	assign rx.ready = !fresh_q || advance;

	assign start_cnt_next = start_cnt_q + 32'd1;
	assign type_cnt_next  = type_cnt_q + 32'(dec.type_match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q     <= 1'b0;
			out_valid_q <= 1'b0;
			start_cnt_q <= '0;
			type_cnt_q  <= '0;
		end else begin
			if (rx_acc) begin
				fresh_q <= 1'b1;
			end else if (advance) begin
				fresh_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				start_cnt_q <= start_cnt_next;
				type_cnt_q  <= type_cnt_next;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		load_res                   = dec;
		load_res.starts_seen       = start_cnt_next;
		load_res.type_matches_seen = type_cnt_next;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	`ISP_ASSERT_NEXT(a_start_cnt_step, load, start_cnt_q == $past(start_cnt_q) + 32'd1)
	`ISP_ASSERT_NEXT(a_type_cnt_hold, !load, $stable(type_cnt_q))
	`ISP_ASSERT_IMPL(a_accept_needs_type, out_valid_q && res_q.frame_accepted, res_q.type_match)
	`ISP_ASSERT_IMPL(a_count_limit, out_valid_q, res_q.analog_count <= 3'(MAX_CHANNELS))
	`ISP_ASSERT_IMPL(a_no_shift_undecoded, rx_acc && fresh_q, advance)
endmodule

// ===== tb/sv/isp_frame_checker.sv =====
// Checker for the IO-sample frame parser: predicts frame results from accepted bytes and compares them.
`timescale 1ns / 1ps
module isp_frame_checker #(
	parameter int WINDOW_BYTES = 29,
	parameter int MAX_CHANNELS = 4
) (
	input logic   clk,
	input logic   arst_n,
	isp_byte_if   rx,
	isp_result_if res,
	isp_cfg_if    cfg,
	output int    fail_count,
	output int    frames_pending
);
	import isp_pkg::*;

	logic [7:0]  rx_window [WINDOW_BYTES];
	logic [31:0] start_total;
	logic [31:0] type_total;
	isp_cfg_t    regs;
	isp_result_t expected_frames [$];

	// Byte at a frame offset counted down from the oldest window position.
	function automatic logic [7:0] byte_at(input int offset);
		int pos;
		pos = WINDOW_BYTES - 1 - offset;
		if (pos < 0 || pos >= WINDOW_BYTES)
			return 8'h00;
		return rx_window[pos];
	endfunction

	task automatic clear_state();
		foreach (rx_window[i])
			rx_window[i] = 8'h00;
		start_total = '0;
		type_total = '0;
		regs.start_marker = RST_START_MARKER;
		regs.wanted_frame_type = RST_WANTED_TYPE;
		regs.node_one_low_address = RST_NODE_ONE;
		regs.node_two_low_address = RST_NODE_TWO;
		regs.node_three_low_address = RST_NODE_THREE;
		expected_frames.delete();
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		case (idx)
			REG_START_MARKER: regs.start_marker = value[7:0];
			REG_WANTED_TYPE:  regs.wanted_frame_type = value[7:0];
			REG_NODE_ONE:     regs.node_one_low_address = value;
			REG_NODE_TWO:     regs.node_two_low_address = value;
			REG_NODE_THREE:   regs.node_three_low_address = value;
			default: ;
		endcase
	endtask

	task automatic shift_and_decode(input logic [7:0] b);
		isp_result_t r;
		logic [7:0]  sum;
		logic [7:0]  amask;
		logic [15:0] smp;
		logic [31:0] low;
		int          active;
		int          k;
		for (k = WINDOW_BYTES - 1; k > 0; k--)
			rx_window[k] = rx_window[k - 1];
		rx_window[0] = b;
		if (rx_window[WINDOW_BYTES - 1] != regs.start_marker)
			return;
		start_total++;
		r = '0;
		for (k = 4; k <= 11; k++)
			r.source_address = {r.source_address[55:0], byte_at(k)};
		r.network_address = {byte_at(12), byte_at(13)};
		// The checksum covers the frame type through the analog mask, then the samples.
		sum = byte_at(3);
		for (k = 4; k <= 18; k++)
			sum += byte_at(k);
		amask = byte_at(18);
		active = 0;
		for (k = 0; k < 4; k++)
			if (amask[k])
				active++;
		if (active > MAX_CHANNELS)
			active = MAX_CHANNELS;
		for (k = 0; k < active; k++) begin
			smp = {byte_at(19 + 2 * k), byte_at(20 + 2 * k)};
			sum += smp[15:8];
			sum += smp[7:0];
			case (k)
				0: r.sample_zero = smp;
				1: r.sample_one = smp;
				2: r.sample_two = smp;
				default: r.sample_three = smp;
			endcase
		end
		r.analog_count = 3'(active);
		r.type_match = (byte_at(3) == regs.wanted_frame_type);
		if (r.type_match)
			type_total++;
		r.frame_accepted = r.type_match && ((CHECKSUM_BASE - sum) == byte_at(19 + 2 * active));
		low = r.source_address[31:0];
		if (low == regs.node_one_low_address)
			r.node_class = NODE_ONE;
		else if (low == regs.node_two_low_address)
			r.node_class = NODE_TWO;
		else if (low == regs.node_three_low_address)
			r.node_class = NODE_THREE;
		else
			r.node_class = NODE_UNKNOWN;
		r.starts_seen = start_total;
		r.type_matches_seen = type_total;
		expected_frames.push_back(r);
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	task automatic check_result(input isp_result_t got);
		isp_result_t want;
		if (expected_frames.size() == 0) begin
			report_mismatch("result transaction with no frame expected");
			return;
		end
		want = expected_frames.pop_front();
		check_field("frame_accepted", 64'(want.frame_accepted), 64'(got.frame_accepted));
		check_field("type_match", 64'(want.type_match), 64'(got.type_match));
		check_field("source_address", want.source_address, got.source_address);
		check_field("network_address", 64'(want.network_address), 64'(got.network_address));
		check_field("node_class", 64'(want.node_class), 64'(got.node_class));
		check_field("analog_count", 64'(want.analog_count), 64'(got.analog_count));
		check_field("sample_zero", 64'(want.sample_zero), 64'(got.sample_zero));
		check_field("sample_one", 64'(want.sample_one), 64'(got.sample_one));
		check_field("sample_two", 64'(want.sample_two), 64'(got.sample_two));
		check_field("sample_three", 64'(want.sample_three), 64'(got.sample_three));
		check_field("starts_seen", 64'(want.starts_seen), 64'(got.starts_seen));
		check_field("type_matches_seen", 64'(want.type_matches_seen),
			64'(got.type_matches_seen));
	endtask

	initial begin
		fail_count = 0;
		frames_pending = 0;
		clear_state();
	end

	// Results are compared before the new byte is predicted: a byte never yields a result at once.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (res.valid && res.ready)
				check_result(res.data);
			if (cfg.valid && cfg.ready)
				write_register(cfg.index, cfg.data);
			if (rx.valid && rx.ready)
				shift_and_decode(rx.rx_byte);
		end
		frames_pending = expected_frames.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the IO-sample frame parser: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
	import isp_pkg::*;

	localparam int RUN_LIMIT       = 400000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int BYTES_PER_PHASE = 270;
	localparam int PHASES          = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

	typedef enum {SMP_ONES, SMP_ZERO, SMP_RANDOM} sample_fill_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          send_idle_pct = 26;
	int          recv_idle_pct = 66;
	int          bytes_sent = 0;
	int          cycle_count = 0;
	int          fail_count;
	int          frames_pending;
	logic [7:0]  cur_marker;
	logic [7:0]  cur_type;
	logic [31:0] cur_node [3];

	isp_byte_if   rxc();
	isp_result_if resc();
	isp_cfg_if    cfgc();

	io_sample_frame_window_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rxc),
		.res    (resc),
		.cfg    (cfgc)
	);

	isp_frame_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rxc),
		.res            (resc),
		.cfg            (cfgc),
		.fail_count     (fail_count),
		.frames_pending (frames_pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		resc.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rxc.valid <= 1'b0;
			@(negedge clk);
		end
		rxc.valid <= 1'b1;
		rxc.rx_byte <= b;
		do
			@(posedge clk);
		while (!rxc.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Leaves valid high; the caller lowers it once the batch of writes is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfgc.valid <= 1'b1;
		cfgc.index <= idx;
		cfgc.data <= value;
		do
			@(posedge clk);
		while (!cfgc.ready);
		@(negedge clk);
		case (idx)
			REG_START_MARKER: cur_marker = value[7:0];
			REG_WANTED_TYPE:  cur_type = value[7:0];
			REG_NODE_ONE:     cur_node[0] = value;
			REG_NODE_TWO:     cur_node[1] = value;
			REG_NODE_THREE:   cur_node[2] = value;
			default: ;
		endcase
	endtask

	// Builds one frame with the current marker; keep > 0 cuts it short after that many bytes.
	task automatic send_frame(input logic [7:0] ftype, input logic [63:0] src,
			input logic [7:0] amask, input bit bad_sum, input sample_fill_t fill, input int keep);
		logic [7:0]  f [$];
		logic [7:0]  sum;
		logic [7:0]  chk;
		logic [15:0] smp;
		int          k;
		f.push_back(cur_marker);
		f.push_back(8'($urandom));
		f.push_back(8'($urandom));
		f.push_back(ftype);
		for (k = 7; k >= 0; k--)
			f.push_back(src[8 * k +: 8]);
		// Network address, receive options, sample count and digital mask.
		repeat (6)
			f.push_back(8'($urandom));
		f.push_back(amask);
		for (k = 0; k < 4; k++) begin
			if (amask[k]) begin
				case (fill)
					SMP_ONES: smp = 16'hFFFF;
					SMP_ZERO: smp = 16'h0000;
					default:  smp = 16'($urandom);
				endcase
				f.push_back(smp[15:8]);
				f.push_back(smp[7:0]);
			end
		end
		sum = '0;
		for (k = 3; k < f.size(); k++)
			sum += f[k];
		chk = CHECKSUM_BASE - sum;
		if (bad_sum)
			chk ^= 8'($urandom_range(1, 255));
		f.push_back(chk);
		if (keep > 0)
			while (f.size() > keep)
				void'(f.pop_back());
		foreach (f[i])
			push_byte(f[i]);
	endtask

	function automatic logic [63:0] pick_source();
		logic [31:0] upper;
		upper = $urandom;
		case ($urandom_range(0, 5))
			0: return {upper, cur_node[0]};
			1: return {upper, cur_node[1]};
			2: return {upper, cur_node[2]};
			3: return '1;
			4: return '0;
			default: return {upper, 32'($urandom)};
		endcase
	endfunction

	task automatic run_traffic(input int target);
		int           stop;
		logic [7:0]   ftype;
		sample_fill_t fill;
		stop = bytes_sent + target;
		while (bytes_sent < stop) begin
			ftype = ($urandom_range(0, 6) == 0) ? 8'($urandom) : cur_type;
			fill = ($urandom_range(0, 7) == 0) ? SMP_ONES : SMP_RANDOM;
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 30))
					push_byte(($urandom_range(0, 7) == 0) ? cur_marker : 8'($urandom));
				1: send_frame(ftype, pick_source(), 8'($urandom), 1'b0, fill,
					$urandom_range(1, 19));
				default: send_frame(ftype, pick_source(), 8'($urandom),
					($urandom_range(0, 4) == 0), fill, 0);
			endcase
		end
	endtask

	task automatic apply_settings(input int phase);
		logic [31:0] shared;
		shared = $urandom;
		case (phase)
			1: begin
				// Zero marker and type; all three node registers equal.
				write_reg(REG_START_MARKER, {24'($urandom), 8'h00});
				write_reg(REG_WANTED_TYPE, {24'($urandom), 8'h00});
				write_reg(REG_NODE_ONE, shared);
				write_reg(REG_NODE_TWO, shared);
				write_reg(REG_NODE_THREE, shared);
			end
			2: begin
				write_reg(REG_START_MARKER, 32'hFFFF_FFFF);
				write_reg(REG_WANTED_TYPE, 32'hFFFF_FFFF);
				write_reg(REG_NODE_ONE, 32'hFFFF_FFFF);
				write_reg(REG_NODE_TWO, 32'h0000_0000);
				write_reg(REG_NODE_THREE, $urandom);
				write_reg(REG_SPARE_LOW, $urandom);
				write_reg(REG_SPARE_HIGH, $urandom);
			end
			3: begin
				write_reg(REG_START_MARKER, $urandom);
				write_reg(REG_WANTED_TYPE, $urandom);
				write_reg(REG_NODE_ONE, $urandom);
				write_reg(REG_NODE_TWO, shared);
				write_reg(REG_NODE_THREE, shared);
			end
			4: begin
				write_reg(REG_START_MARKER, {24'h0, RST_START_MARKER});
				write_reg(REG_WANTED_TYPE, {24'h0, RST_WANTED_TYPE});
				write_reg(REG_NODE_ONE, RST_NODE_ONE);
				write_reg(REG_NODE_TWO, RST_NODE_TWO);
				write_reg(REG_NODE_THREE, RST_NODE_THREE);
			end
			default: begin
				write_reg(REG_START_MARKER, $urandom);
				write_reg(REG_WANTED_TYPE, $urandom);
				write_reg(REG_NODE_ONE, $urandom);
				write_reg(REG_NODE_TWO, $urandom);
				write_reg(REG_NODE_THREE, $urandom);
				write_reg(REG_SPARE_LOW, $urandom);
			end
		endcase
		cfgc.valid <= 1'b0;
	endtask

	initial begin
		int phase;
		rxc.valid = 1'b0;
		rxc.rx_byte = 8'h00;
		cfgc.valid = 1'b0;
		cfgc.index = REG_START_MARKER;
		cfgc.data = 32'h0;
		resc.ready = 1'b0;
		cur_marker = RST_START_MARKER;
		cur_type = RST_WANTED_TYPE;
		cur_node[0] = RST_NODE_ONE;
		cur_node[1] = RST_NODE_TWO;
		cur_node[2] = RST_NODE_THREE;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames: saturating mask with full samples, no samples, bad checksum,
		// wrong type, high mask bits only, and a frame cut short.
		send_frame(cur_type, {32'hFFFF_FFFF, cur_node[0]}, 8'hFF, 1'b0, SMP_ONES, 0);
		send_frame(cur_type, {32'h0, cur_node[1]}, 8'h00, 1'b0, SMP_RANDOM, 0);
		send_frame(cur_type, {32'($urandom), cur_node[2]}, 8'h05, 1'b1, SMP_RANDOM, 0);
		send_frame(~cur_type, '0, 8'h01, 1'b0, SMP_ZERO, 0);
		send_frame(cur_type, '1, 8'hF0, 1'b0, SMP_ZERO, 0);
		send_frame(cur_type, pick_source(), 8'h0A, 1'b0, SMP_RANDOM, 12);
		run_traffic(BYTES_PER_PHASE);

		for (phase = 1; phase < PHASES; phase++) begin
			rxc.valid <= 1'b0;
			while (frames_pending != 0)
				@(negedge clk);
			// A byte still in the decode stage must see the old settings.
			repeat (SETTLE_CYCLES) @(negedge clk);
			case (phase / 2)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 66;
				end
				1: begin
					send_idle_pct = 66;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			apply_settings(phase);
			run_traffic(BYTES_PER_PHASE);
		end

		rxc.valid <= 1'b0;
		while (frames_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/isp_pkg.sv
src/isp_if.sv
src/isp_cell.sv
src/isp_decode.sv
src/io_sample_frame_window_parser.sv
tb/sv/isp_frame_checker.sv
tb/sv/tb_top.sv
